[rtl/ptp_pkg.sv]
// Shared types, constants and helper functions of the partition table parser.
`timescale 1ns / 1ps
package ptp_pkg;

    localparam int UNIT_CAPACITY_DEF = 8;
    localparam int TABLE_ENTRIES     = 4;
    localparam int SECTOR_BYTES      = 512;
    localparam int POS_W             = 9;
    localparam int ADDR_W            = POS_W + 1;
    localparam int UNIT_W            = 7;
    localparam int ENTRY_BYTES       = 16;

    localparam logic [POS_W-1:0] DOS_BASE  = 9'h1BE;
    localparam logic [POS_W-1:0] ALT_BASE  = 9'h1C6;
    localparam logic [POS_W-1:0] POS_SIG0  = 9'h1FE;
    localparam logic [POS_W-1:0] POS_LAST  = 9'h1FF;
    localparam logic [POS_W-1:0] POS_SSHI  = 9'h00B;
    localparam logic [POS_W-1:0] POS_SSLO  = 9'h00C;
    localparam logic [POS_W-1:0] POS_TOT0  = 9'h1C2;
    localparam logic [POS_W-1:0] POS_TOT1  = 9'h1C3;
    localparam logic [POS_W-1:0] POS_TOT2  = 9'h1C4;
    localparam logic [POS_W-1:0] POS_TOT3  = 9'h1C5;

    localparam logic [7:0]  SIG_LO     = 8'h55;
    localparam logic [7:0]  SIG_HI     = 8'hAA;
    localparam logic [7:0]  TYPE_EXT   = 8'h05;
    localparam logic [7:0]  TYPE_EXT_L = 8'h0F;
    localparam logic [7:0]  FLAG_BOOT  = 8'h80;
    localparam logic [7:0]  CHAR_DOT   = 8'h2E;
    localparam logic [23:0] ID_XGM     = 24'h58474D;

    typedef enum logic [1:0] {
        KIND_PART     = 2'd0,
        KIND_FETCH    = 2'd1,
        KIND_DOS_DONE = 2'd2,
        KIND_ALT_DONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_MAIN,
        MODE_EXT,
        MODE_ALT
    } walk_mode_t;

    // One result as held in the output register.
    typedef struct packed {
        kind_t       kind;
        logic [5:0]  lun;
        logic [31:0] start_sector;
        logic [31:0] sector_count;
        logic [7:0]  part_type;
        logic [23:0] table_id;
        logic        bootable;
        logic        extended_mark;
        logic [31:0] total_sectors;
        logic [15:0] sector_size;
        logic        overflow;
        logic        last;
    } result_t;

    // Memory request from the sequencer to the sector store.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // Characters outside the printable range read as a dot.
    function automatic logic [7:0] fix_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c < 8'h20 || c > 8'h7E) begin
            r = CHAR_DOT;
        end
        return r;
    endfunction

endpackage

[rtl/partition_table_parser_unit.sv]
// Top level of the partition table parser: loader, entry sequencer, shared adder, output register.
`timescale 1ns / 1ps
// Usage:
// The slave channel takes one sector byte per request in s_tdata, offset 0 first.
// Bytes are taken at one per cycle while a sector loads. After the 512th byte
// s_tready drops and the sequencer walks the table: each entry is read from the
// sector store one byte per cycle and then judged in the evaluate state, using
// one shared 32-bit adder for the size sum and the extended start offset. A main
// table walk judges four entries and gives one closing result; after an extended
// record it judges at most four extended entries and three remaining main entries
// before the close.
// Results leave on the master channel, kind in m_tuser, the end of a sector's
// run marked by m_tlast. A fetch result asks the source to send the extended
// record as the next 512 bytes.
// When the receiver stalls, the sequencer waits with the next result in hand;
// the output register keeps the current one, and loading resumes as soon as
// the closing result is taken into the output register.
// Reset clears all counters and the output valid; the store contents are not
// cleared and are always written before they are read.
module partition_table_parser_unit #(
    parameter int UNIT_CAPACITY = ptp_pkg::UNIT_CAPACITY_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] lun, [37:6] start_sector, [69:38] sector_count, [77:70] part_type,
    // [101:78] table_id, [102] bootable, [103] extended_mark,
    // [135:104] total_sectors, [151:136] sector_size, [152] overflow, rest zero
    output logic [159:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast
);

    localparam logic [ptp_pkg::UNIT_W-1:0] CAP = ptp_pkg::UNIT_W'(UNIT_CAPACITY);
    localparam logic [2:0] LAST_IDX = 3'(ptp_pkg::TABLE_ENTRIES - 1);
    localparam logic [2:0] END_IDX  = 3'(ptp_pkg::TABLE_ENTRIES);
    localparam logic [4:0] RD_END   = 5'(ptp_pkg::ENTRY_BYTES);

    ptp_pkg::state_t     state_reg, state_next;
    ptp_pkg::walk_mode_t mode_reg, mode_next;
    logic [ptp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       phase_reg, phase_next;
    logic [2:0]                 entry_index_reg, entry_index_next;
    logic [2:0]                 walk_idx_reg, walk_idx_next;
    logic [ptp_pkg::UNIT_W-1:0] unit_count_reg, unit_count_next;
    logic [31:0]                size_sum_reg, size_sum_next;
    logic [31:0]                ext_base_reg, ext_base_next;
    logic                       dropped_reg, dropped_next;
    logic [4:0]                 rd_cnt_reg, rd_cnt_next;
    logic [7:0]                 ent_reg [ptp_pkg::ENTRY_BYTES];
    logic [7:0]                 ent_next [ptp_pkg::ENTRY_BYTES];
    logic [7:0]                 sig_lo_reg, sig_lo_next;
    logic [15:0]                ssize_reg, ssize_next;
    logic [31:0]                alt_total_reg, alt_total_next;
    ptp_pkg::result_t           out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    ptp_pkg::mem_req_t mem_req;
    logic [7:0]        mem_rdata;

    logic              in_acc;
    logic              out_free;
    logic [2:0]        cur_idx;
    logic [ptp_pkg::POS_W-1:0] ent_base;
    logic [31:0]       add_a, add_b, add_sum;
    logic [31:0]       le_start, le_count, be_start, be_count;
    logic [7:0]        e_type;
    logic [23:0]       alt_id;
    logic              sig_now;

    ptp_sector_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ptp_pkg::ST_LOAD);
    assign sig_now  = (sig_lo_reg == ptp_pkg::SIG_LO) && (s_tdata == ptp_pkg::SIG_HI);

    // Fields of the entry held in the gather buffer.
    assign e_type   = ent_reg[4];
    assign le_start = {ent_reg[11], ent_reg[10], ent_reg[9], ent_reg[8]};
    assign le_count = {ent_reg[15], ent_reg[14], ent_reg[13], ent_reg[12]};
    assign be_start = {ent_reg[4], ent_reg[5], ent_reg[6], ent_reg[7]};
    assign be_count = {ent_reg[8], ent_reg[9], ent_reg[10], ent_reg[11]};
    assign alt_id   = {ptp_pkg::fix_char(ent_reg[1]), ptp_pkg::fix_char(ent_reg[2]),
                       ptp_pkg::fix_char(ent_reg[3])};

    // The one shared adder: size sum on the main table, start offset on the extended one.
    assign add_a   = (mode_reg == ptp_pkg::MODE_EXT) ? ext_base_reg : size_sum_reg;
    assign add_b   = (mode_reg == ptp_pkg::MODE_EXT) ? le_start : le_count;
    assign add_sum = add_a + add_b;

    // Entry address within the current sector.
    assign cur_idx = (mode_reg == ptp_pkg::MODE_MAIN) ? entry_index_reg : walk_idx_reg;
    always_comb begin
        if (mode_reg == ptp_pkg::MODE_ALT) begin
            ent_base = ptp_pkg::ALT_BASE + ptp_pkg::POS_W'({cur_idx, 2'b00})
                     + ptp_pkg::POS_W'({cur_idx, 3'b000});
        end else begin
            ent_base = ptp_pkg::DOS_BASE + ptp_pkg::POS_W'({cur_idx, 4'b0000});
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ptp_pkg::ST_LOAD;
            mode_reg        <= ptp_pkg::MODE_MAIN;
            pos_reg         <= '0;
            phase_reg       <= 1'b0;
            entry_index_reg <= '0;
            walk_idx_reg    <= '0;
            unit_count_reg  <= '0;
            size_sum_reg    <= '0;
            ext_base_reg    <= '0;
            dropped_reg     <= 1'b0;
            rd_cnt_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            entry_index_reg <= entry_index_next;
            walk_idx_reg    <= walk_idx_next;
            unit_count_reg  <= unit_count_next;
            size_sum_reg    <= size_sum_next;
            ext_base_reg    <= ext_base_next;
            dropped_reg     <= dropped_next;
            rd_cnt_reg      <= rd_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        ent_reg       <= ent_next;
        sig_lo_reg    <= sig_lo_next;
        ssize_reg     <= ssize_next;
        alt_total_reg <= alt_total_next;
        out_reg       <= out_next;
    end

    // Sequencer: load, read entry, judge entry, close the run.
    always_comb begin
        logic       rep_want;
        logic [31:0] rep_start, rep_count;
        logic [7:0]  rep_type;
        logic [23:0] rep_id;
        logic        rep_boot, rep_ext;
        logic        next_read;

        state_next       = state_reg;
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        entry_index_next = entry_index_reg;
        walk_idx_next    = walk_idx_reg;
        unit_count_next  = unit_count_reg;
        size_sum_next    = size_sum_reg;
        ext_base_next    = ext_base_reg;
        dropped_next     = dropped_reg;
        rd_cnt_next      = rd_cnt_reg;
        ent_next         = ent_reg;
        sig_lo_next      = sig_lo_reg;
        ssize_next       = ssize_reg;
        alt_total_next   = alt_total_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        mem_req          = '0;
        rep_want         = 1'b0;
        rep_start        = '0;
        rep_count        = '0;
        rep_type         = '0;
        rep_id           = '0;
        rep_boot         = 1'b0;
        rep_ext          = 1'b0;
        next_read        = 1'b0;

        case (state_reg)
            ptp_pkg::ST_LOAD: begin
                if (in_acc) begin
                    mem_req.we    = 1'b1;
                    mem_req.addr  = {phase_reg, pos_reg};
                    mem_req.wdata = s_tdata;
                    pos_next      = pos_reg + 1'b1;
                    if (pos_reg == ptp_pkg::POS_SIG0) begin
                        sig_lo_next = s_tdata;
                    end
                    // Sector size and total bytes of the main sector are kept as they pass.
                    if (!phase_reg) begin
                        if (pos_reg == ptp_pkg::POS_SSHI) ssize_next[15:8] = s_tdata;
                        if (pos_reg == ptp_pkg::POS_SSLO) ssize_next[7:0] = s_tdata;
                        if (pos_reg == ptp_pkg::POS_TOT0) alt_total_next[31:24] = s_tdata;
                        if (pos_reg == ptp_pkg::POS_TOT1) alt_total_next[23:16] = s_tdata;
                        if (pos_reg == ptp_pkg::POS_TOT2) alt_total_next[15:8] = s_tdata;
                        if (pos_reg == ptp_pkg::POS_TOT3) alt_total_next[7:0] = s_tdata;
                    end
                    if (pos_reg == ptp_pkg::POS_LAST) begin
                        phase_next    = 1'b0;
                        walk_idx_next = '0;
                        rd_cnt_next   = '0;
                        if (phase_reg) begin
                            if (sig_now) begin
                                mode_next  = ptp_pkg::MODE_EXT;
                                state_next = ptp_pkg::ST_READ;
                            end else begin
                                mode_next  = ptp_pkg::MODE_MAIN;
                                state_next = (entry_index_reg == END_IDX) ?
                                             ptp_pkg::ST_DONE : ptp_pkg::ST_READ;
                            end
                        end else begin
                            entry_index_next = '0;
                            mode_next  = sig_now ? ptp_pkg::MODE_MAIN : ptp_pkg::MODE_ALT;
                            state_next = ptp_pkg::ST_READ;
                        end
                    end
                end
            end

            ptp_pkg::ST_READ: begin
                // The address goes out, and its byte lands in the buffer in the next cycle.
                if (rd_cnt_reg != RD_END) begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = {mode_reg == ptp_pkg::MODE_EXT,
                                    ent_base + ptp_pkg::POS_W'(rd_cnt_reg[3:0])};
                end
                if (rd_cnt_reg != 5'd0) begin
                    ent_next[4'(rd_cnt_reg - 5'd1)] = mem_rdata;
                end
                if (rd_cnt_reg == RD_END) begin
                    state_next = ptp_pkg::ST_EVAL;
                end
                rd_cnt_next = rd_cnt_reg + 5'd1;
            end

            ptp_pkg::ST_EVAL: begin
                if (out_free) begin
                    rd_cnt_next = '0;
                    case (mode_reg)
                        ptp_pkg::MODE_MAIN: begin
                            size_sum_next    = add_sum;
                            entry_index_next = entry_index_reg + 3'd1;
                            rep_want  = (e_type != 8'h00) && (e_type != ptp_pkg::TYPE_EXT)
                                        && (e_type != ptp_pkg::TYPE_EXT_L);
                            rep_start = le_start;
                            rep_count = le_count;
                            rep_type  = e_type;
                            rep_boot  = (ent_reg[0] != 8'h00);
                            if (e_type == ptp_pkg::TYPE_EXT_L) begin
                                // Extended link: ask for the record and load it next.
                                ext_base_next  = le_start;
                                phase_next     = 1'b1;
                                out_next       = '0;
                                out_next.kind  = ptp_pkg::KIND_FETCH;
                                out_next.start_sector = le_start;
                                out_next.last  = 1'b1;
                                out_valid_next = 1'b1;
                                state_next     = ptp_pkg::ST_LOAD;
                            end else if (entry_index_reg == LAST_IDX) begin
                                state_next = ptp_pkg::ST_DONE;
                            end else begin
                                state_next = ptp_pkg::ST_READ;
                            end
                        end
                        ptp_pkg::MODE_EXT: begin
                            walk_idx_next = walk_idx_reg + 3'd1;
                            rep_want  = (e_type != 8'h00);
                            rep_start = add_sum;
                            rep_count = le_count;
                            rep_type  = e_type;
                            rep_boot  = (ent_reg[0] != 8'h00);
                            rep_ext   = 1'b1;
                            if (walk_idx_reg == LAST_IDX) begin
                                mode_next  = ptp_pkg::MODE_MAIN;
                                state_next = (entry_index_reg == END_IDX) ?
                                             ptp_pkg::ST_DONE : ptp_pkg::ST_READ;
                            end else begin
                                state_next = ptp_pkg::ST_READ;
                            end
                        end
                        default: begin
                            walk_idx_next = walk_idx_reg + 3'd1;
                            rep_want  = ent_reg[0][0];
                            rep_start = be_start;
                            rep_count = be_count;
                            rep_type  = ent_reg[0];
                            rep_id    = alt_id;
                            rep_boot  = (ent_reg[0] & ptp_pkg::FLAG_BOOT) != 8'h00;
                            rep_ext   = (alt_id == ptp_pkg::ID_XGM);
                            next_read = (walk_idx_reg != LAST_IDX);
                            state_next = next_read ? ptp_pkg::ST_READ : ptp_pkg::ST_DONE;
                        end
                    endcase
                    // Partition report, or a drop once every unit is taken.
                    if (rep_want) begin
                        if (unit_count_reg >= CAP) begin
                            dropped_next = 1'b1;
                        end else begin
                            out_next               = '0;
                            out_next.kind          = ptp_pkg::KIND_PART;
                            out_next.lun           = unit_count_reg[5:0];
                            out_next.start_sector  = rep_start;
                            out_next.sector_count  = rep_count;
                            out_next.part_type     = rep_type;
                            out_next.table_id      = rep_id;
                            out_next.bootable      = rep_boot;
                            out_next.extended_mark = rep_ext;
                            out_valid_next         = 1'b1;
                            unit_count_next        = unit_count_reg + 1'b1;
                        end
                    end
                end
            end

            ptp_pkg::ST_DONE: begin
                if (out_free) begin
                    out_next = '0;
                    if (mode_reg == ptp_pkg::MODE_ALT) begin
                        out_next.kind          = ptp_pkg::KIND_ALT_DONE;
                        out_next.total_sectors = alt_total_reg;
                    end else begin
                        out_next.kind          = ptp_pkg::KIND_DOS_DONE;
                        out_next.total_sectors = size_sum_reg;
                        out_next.sector_size   = ssize_reg;
                    end
                    out_next.overflow = dropped_reg;
                    out_next.last     = 1'b1;
                    out_valid_next    = 1'b1;
                    // Start a fresh run.
                    phase_next       = 1'b0;
                    entry_index_next = '0;
                    unit_count_next  = '0;
                    size_sum_next    = '0;
                    ext_base_next    = '0;
                    dropped_next     = 1'b0;
                    mode_next        = ptp_pkg::MODE_MAIN;
                    state_next       = ptp_pkg::ST_LOAD;
                end
            end

            default: begin
                state_next = ptp_pkg::ST_LOAD;
            end
        endcase
    end

    // Output channel.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.overflow, out_reg.sector_size, out_reg.total_sectors,
                       out_reg.extended_mark, out_reg.bootable, out_reg.table_id,
                       out_reg.part_type, out_reg.sector_count, out_reg.start_sector,
                       out_reg.lun};

    // The unit count never passes the capacity.
    a_unit_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_count_reg <= CAP)
        else $error("unit count beyond capacity");

    // Every result but a partition report carries the end mark, the fetch included.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != ptp_pkg::KIND_PART)))
        else $error("end mark on wrong result kind");

    // The final byte of a sector stops further requests until the walk ends.
    a_stop_after_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && pos_reg == ptp_pkg::POS_LAST) |=> !s_tready)
        else $error("input taken during table walk");

    // The main entry index stays within the table.
    a_entry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_index_reg <= END_IDX)
        else $error("entry index beyond table");

    // A new result is loaded only when the previous one has gone or is going.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("stalled result overwritten");

endmodule

[rtl/ptp_sector_mem.sv]
// Byte store for the main and extended sectors, one write or read port, registered read.
`timescale 1ns / 1ps
module ptp_sector_mem (
    input  logic                        aclk,
    input  ptp_pkg::mem_req_t           req,
    output logic [7:0]                  rdata
);

    localparam int DEPTH = 2 * ptp_pkg::SECTOR_BYTES;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write on request; read data is registered and appears in the cycle after the address.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
